>>> hw/rtl/sorted_list_engine_unit_defines.svh
// ---------------------------------------------------------------------------
// sorted_list_engine_unit_defines
// Assertion macros for the sorted list engine. Each macro takes a label,
// an antecedent and a consequent, and expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLE_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_list_engine_unit: same-cycle check failed");

// next-cycle implication
`define SLE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_list_engine_unit: next-cycle check failed");

`else

`define SLE_ASSERT_IMP(name, ante, cons)
`define SLE_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> hw/rtl/sle_pkg.sv
// ---------------------------------------------------------------------------
// sle_pkg
// Widths, command and error codes, datapath micro-ops and the
// controller/datapath structs of the sorted list engine.
// ---------------------------------------------------------------------------
package sle_pkg;

	localparam int DATA_W       = 32;
	localparam int CMD_W        = 3;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int ERR_W        = 2;
	localparam int CAPACITY_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd5;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
	localparam logic [ERR_W-1:0] ERR_INDEX = 2'd3;

	localparam int OP_W = 5;

	localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
	localparam logic [OP_W-1:0] OP_SET_ERR   = 5'd2;
	localparam logic [OP_W-1:0] OP_SETUP_INS = 5'd3;
	localparam logic [OP_W-1:0] OP_SETUP_APP = 5'd4;
	localparam logic [OP_W-1:0] OP_SETUP_REV = 5'd5;
	localparam logic [OP_W-1:0] OP_SRCH_RD   = 5'd6;
	localparam logic [OP_W-1:0] OP_SRCH_NEXT = 5'd7;
	localparam logic [OP_W-1:0] OP_SH_RD     = 5'd8;
	localparam logic [OP_W-1:0] OP_SH_WR     = 5'd9;
	localparam logic [OP_W-1:0] OP_PUT       = 5'd10;
	localparam logic [OP_W-1:0] OP_REMOVE    = 5'd11;
	localparam logic [OP_W-1:0] OP_RD_IDX    = 5'd12;
	localparam logic [OP_W-1:0] OP_CAP_RD    = 5'd13;
	localparam logic [OP_W-1:0] OP_RV_RD     = 5'd14;
	localparam logic [OP_W-1:0] OP_RV_WK     = 5'd15;
	localparam logic [OP_W-1:0] OP_RV_WI     = 5'd16;
	localparam logic [OP_W-1:0] OP_SWAP      = 5'd17;
	localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd18;
	localparam logic [OP_W-1:0] OP_SCAN      = 5'd19;
	localparam logic [OP_W-1:0] OP_PUBLISH   = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ERR_W-1:0] err;
	} sle_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             idx_bad;
		logic             i_eq_count;
		logic             k_eq_i;
		logic             i_lt_k;
		logic             le;
		logic             scan_done;
		logic             out_free;
	} sle_stat_t;

	// signed a <= b
	function automatic logic le_s(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
		return $signed(a) <= $signed(b);
	endfunction

endpackage

>>> hw/rtl/sle_req_if.sv
// ---------------------------------------------------------------------------
// sle_req_if
// Command channel: valid/ready handshake with one command per transaction.
// ---------------------------------------------------------------------------
interface sle_req_if import sle_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] value;
	logic [IDX_W-1:0]         index;

	modport source (output valid, output command, output value, output index, input ready);
	modport sink (input valid, input command, input value, input index, output ready);

endinterface

>>> hw/rtl/sle_rsp_if.sv
// ---------------------------------------------------------------------------
// sle_rsp_if
// Result channel: valid/ready handshake with one result per transaction.
// ---------------------------------------------------------------------------
interface sle_rsp_if import sle_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         entry_count;
	logic                     is_ascending;
	logic                     is_descending;
	logic [ERR_W-1:0]         error_code;

	modport source (
		output valid, output read_value, output entry_count,
		output is_ascending, output is_descending, output error_code, input ready
	);
	modport sink (
		input valid, input read_value, input entry_count,
		input is_ascending, input is_descending, input error_code, output ready
	);

endinterface

>>> hw/rtl/sle_ctrl.sv
// ---------------------------------------------------------------------------
// sle_ctrl
// Sequencer of the sorted list engine: decodes each command and steps the
// datapath through search, shift, swap, order scan and result publish.
// ---------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  sle_stat_t stat,
	output sle_ctl_t  ctl
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DECODE    = 4'd1;
	localparam logic [3:0] S_SRCH_RD   = 4'd2;
	localparam logic [3:0] S_SRCH_CMP  = 4'd3;
	localparam logic [3:0] S_SH_RD     = 4'd4;
	localparam logic [3:0] S_SH_WR     = 4'd5;
	localparam logic [3:0] S_RD_CAP    = 4'd6;
	localparam logic [3:0] S_RV_RD     = 4'd7;
	localparam logic [3:0] S_RV_WK     = 4'd8;
	localparam logic [3:0] S_RV_WI     = 4'd9;
	localparam logic [3:0] S_SCAN_INIT = 4'd10;
	localparam logic [3:0] S_SCAN      = 4'd11;
	localparam logic [3:0] S_DONE      = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl.op    = OP_NOP;
		ctl.err   = ERR_OK;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_INSERT, CMD_PREPEND, CMD_APPEND: begin
						if (stat.full) begin
							ctl.op  = OP_SET_ERR;
							ctl.err = ERR_FULL;
							state_d = S_DONE;
						end else if (stat.cmd == CMD_INSERT) begin
							ctl.op  = OP_SETUP_INS;
							state_d = S_SRCH_RD;
						end else if (stat.cmd == CMD_PREPEND) begin
							ctl.op  = OP_SETUP_INS;
							state_d = S_SH_RD;
						end else begin
							ctl.op  = OP_SETUP_APP;
							state_d = S_SH_RD;
						end
					end
					CMD_REMOVE: begin
						if (stat.empty) begin
							ctl.op  = OP_SET_ERR;
							ctl.err = ERR_EMPTY;
							state_d = S_DONE;
						end else begin
							ctl.op  = OP_REMOVE;
							state_d = S_SCAN_INIT;
						end
					end
					CMD_READ: begin
						priority if (stat.empty) begin
							ctl.op  = OP_SET_ERR;
							ctl.err = ERR_EMPTY;
							state_d = S_DONE;
						end else if (stat.idx_bad) begin
							ctl.op  = OP_SET_ERR;
							ctl.err = ERR_INDEX;
							state_d = S_DONE;
						end else begin
							ctl.op  = OP_RD_IDX;
							state_d = S_RD_CAP;
						end
					end
					CMD_REVERSE: begin
						if (stat.empty) begin
							state_d = S_DONE;
						end else begin
							ctl.op  = OP_SETUP_REV;
							state_d = S_RV_RD;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SRCH_RD: begin
				if (stat.i_eq_count) begin
					state_d = S_SH_RD;
				end else begin
					ctl.op  = OP_SRCH_RD;
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.le) begin
					ctl.op  = OP_SRCH_NEXT;
					state_d = S_SRCH_RD;
				end else begin
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (stat.k_eq_i) begin
					ctl.op  = OP_PUT;
					state_d = S_SCAN_INIT;
				end else begin
					ctl.op  = OP_SH_RD;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				ctl.op  = OP_SH_WR;
				state_d = S_SH_RD;
			end
			S_RD_CAP: begin
				ctl.op  = OP_CAP_RD;
				state_d = S_DONE;
			end
			S_RV_RD: begin
				if (stat.i_lt_k) begin
					ctl.op  = OP_RV_RD;
					state_d = S_RV_WK;
				end else begin
					ctl.op  = OP_SWAP;
					state_d = S_DONE;
				end
			end
			S_RV_WK: begin
				ctl.op  = OP_RV_WK;
				state_d = S_RV_WI;
			end
			S_RV_WI: begin
				ctl.op  = OP_RV_WI;
				state_d = S_RV_RD;
			end
			S_SCAN_INIT: begin
				ctl.op  = OP_SCAN_INIT;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				ctl.op = OP_SCAN;
				if (stat.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.op  = OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/sle_datapath.sv
// ---------------------------------------------------------------------------
// sle_datapath
// Entry memory, count, work pointers, order flags and the result register
// of the sorted list engine, driven one micro-op per cycle.
// ---------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sle_ctl_t        ctl,
	output sle_stat_t       stat,
	sle_req_if.sink         req,
	sle_rsp_if.source       rsp
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int IXW = (CW > IDX_W) ? CW : IDX_W;
	localparam int EXW = (CW > CNT_W) ? CW : CNT_W;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rd0_q;
	logic [DATA_W-1:0] rd1_q;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     k_q;
	logic              asc_q;
	logic              desc_q;
	logic              pend_q;
	logic              have_prev_q;
	logic [DATA_W-1:0] prev_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]  index_q;
	logic [DATA_W-1:0] res_value_q;
	logic [ERR_W-1:0]  err_q;

	logic              rsp_valid_q;
	logic [DATA_W-1:0] rsp_value_q;
	logic [CNT_W-1:0]  rsp_count_q;
	logic              rsp_asc_q;
	logic              rsp_desc_q;
	logic [ERR_W-1:0]  rsp_err_q;

	logic [CW-1:0]     km1;
	logic [IXW-1:0]    idx_ext;
	logic [IXW-1:0]    cnt_ix;
	logic [EXW-1:0]    cnt_ext;
	logic              i_lt_count;

	logic              rd0_en;
	logic [AW-1:0]     rd0_addr;
	logic              rd1_en;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign km1        = k_q - CW'(1);
	assign idx_ext    = IXW'(index_q);
	assign cnt_ix     = IXW'(count_q);
	assign cnt_ext    = EXW'(count_q);
	assign i_lt_count = i_q < count_q;

	always_comb begin
		rd0_en   = 1'b0;
		rd0_addr = i_q[AW-1:0];
		rd1_en   = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = i_q[AW-1:0];
		wr_data  = value_q;
		unique case (ctl.op)
			OP_SRCH_RD: begin
				rd0_en = 1'b1;
			end
			OP_SH_RD: begin
				rd0_en   = 1'b1;
				rd0_addr = km1[AW-1:0];
			end
			OP_RD_IDX: begin
				rd0_en   = 1'b1;
				rd0_addr = idx_ext[AW-1:0];
			end
			OP_RV_RD: begin
				rd0_en = 1'b1;
				rd1_en = 1'b1;
			end
			OP_SCAN: begin
				rd0_en = i_lt_count;
			end
			OP_SH_WR, OP_RV_WK: begin
				wr_en   = 1'b1;
				wr_addr = k_q[AW-1:0];
				wr_data = rd0_q;
			end
			OP_PUT: begin
				wr_en = 1'b1;
			end
			OP_RV_WI: begin
				wr_en   = 1'b1;
				wr_data = rd1_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd0_en) begin
			rd0_q <= mem[rd0_addr];
		end
		if (rd1_en) begin
			rd1_q <= mem[k_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			i_q         <= '0;
			k_q         <= '0;
			asc_q       <= 1'b1;
			desc_q      <= 1'b1;
			pend_q      <= 1'b0;
			have_prev_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.op == OP_PUBLISH) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (ctl.op)
				OP_SETUP_INS: begin
					i_q <= '0;
					k_q <= count_q;
				end
				OP_SETUP_APP: begin
					i_q <= count_q;
					k_q <= count_q;
				end
				OP_SETUP_REV: begin
					i_q <= '0;
					k_q <= count_q - CW'(1);
				end
				OP_SRCH_NEXT: begin
					i_q <= i_q + CW'(1);
				end
				OP_SH_WR: begin
					k_q <= km1;
				end
				OP_PUT: begin
					count_q <= count_q + CW'(1);
				end
				OP_REMOVE: begin
					count_q <= count_q - CW'(1);
				end
				OP_RV_WI: begin
					i_q <= i_q + CW'(1);
					k_q <= km1;
				end
				OP_SWAP: begin
					asc_q  <= desc_q;
					desc_q <= asc_q;
				end
				OP_SCAN_INIT: begin
					i_q         <= '0;
					asc_q       <= 1'b1;
					desc_q      <= 1'b1;
					pend_q      <= 1'b0;
					have_prev_q <= 1'b0;
				end
				OP_SCAN: begin
					if (i_lt_count) begin
						i_q <= i_q + CW'(1);
					end
					pend_q <= i_lt_count;
					if (pend_q) begin
						have_prev_q <= 1'b1;
						if (have_prev_q) begin
							asc_q  <= asc_q & le_s(prev_q, rd0_q);
							desc_q <= desc_q & le_s(rd0_q, prev_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				cmd_q       <= req.command;
				value_q     <= req.value;
				index_q     <= req.index;
				res_value_q <= '0;
				err_q       <= ERR_OK;
			end
			OP_SET_ERR: begin
				err_q <= ctl.err;
			end
			OP_CAP_RD: begin
				res_value_q <= rd0_q;
			end
			OP_SCAN: begin
				if (pend_q) begin
					prev_q <= rd0_q;
				end
			end
			OP_PUBLISH: begin
				rsp_value_q <= res_value_q;
				rsp_count_q <= cnt_ext[CNT_W-1:0];
				rsp_asc_q   <= asc_q;
				rsp_desc_q  <= desc_q;
				rsp_err_q   <= err_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.cmd        = cmd_q;
	assign stat.full       = count_q == CW'(CAPACITY);
	assign stat.empty      = count_q == '0;
	assign stat.idx_bad    = idx_ext >= cnt_ix;
	assign stat.i_eq_count = i_q == count_q;
	assign stat.k_eq_i     = k_q == i_q;
	assign stat.i_lt_k     = i_q < k_q;
	assign stat.le         = le_s(rd0_q, value_q);
	assign stat.scan_done  = (i_q == count_q) && !pend_q;
	assign stat.out_free   = !rsp_valid_q || rsp.ready;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_value    = rsp_value_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.is_ascending  = rsp_asc_q;
	assign rsp.is_descending = rsp_desc_q;
	assign rsp.error_code    = rsp_err_q;

endmodule

>>> hw/rtl/sorted_list_engine_unit.sv
// ---------------------------------------------------------------------------
// sorted_list_engine_unit
// Ordered list of up to CAPACITY signed 32-bit entries driven by commands.
// ---------------------------------------------------------------------------
// req carries one command per transaction; rsp returns exactly one result
// for each: read value, entry count, order flags, error code. One command
// is in work at a time; req.ready is high while the sequencer is idle, also
// while the previous result still waits on rsp. Steps from acceptance to
// rsp.valid: errors, unused codes and reverse of an empty list go straight
// to publish; read_at reads and captures the entry at index; remove_last
// drops the last entry and rescans the order; append, prepend and
// insert_sorted shift entries up from the back to the insert point (found
// by a search from the front for insert_sorted), write the value and
// rescan the order; reverse swaps entry pairs from both ends inward, then
// swaps the order flags.
// The entry memory has one write and two registered read ports.
// Reset empties the list and sets both order flags; the memory keeps its
// contents. When rsp stalls, the result holds in the output register and
// the next command waits before publish.
// ---------------------------------------------------------------------------
`include "sorted_list_engine_unit_defines.svh"

module sorted_list_engine_unit import sle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);

	sle_ctl_t  ctl;
	sle_stat_t stat;
	logic      in_ready;

	assign req.ready = in_ready;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (in_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	sle_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

	`SLE_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
	`SLE_ASSERT_IMP(a_err_zero_value, rsp.valid && (rsp.error_code != ERR_OK), rsp.read_value == '0)
	`SLE_ASSERT_IMP(a_put_not_full, ctl.op == OP_PUT, !stat.full)
	`SLE_ASSERT_IMP(a_publish_free, ctl.op == OP_PUBLISH, stat.out_free)

endmodule

>>> tb/sv/sorted_list_engine_unit_test.sv
// ---------------------------------------------------------------------------
// sorted_list_engine_unit_test
// Self-checking bench for the sorted list engine. A clocked driver feeds
// list commands from a backlog and a clocked monitor checks every status
// transaction against a behavioral list kept alongside the engine. The run
// covers empty, full and bad-index errors, all six commands plus the unused
// codes, and random build, drain and mixed command sequences under several
// sender and receiver idle patterns.
// ---------------------------------------------------------------------------
module sorted_list_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sle_pkg::*;

	localparam int LIST_DEPTH     = CAPACITY_DEF;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS   = 600;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 250;
	localparam int ITEMS_PER_PHASE = 40;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
	} list_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         entry_count;
		logic                     is_ascending;
		logic                     is_descending;
		logic [ERR_W-1:0]         error_code;
	} list_status_t;

	logic clk = 1'b0;
	logic arst_n;

	sle_req_if req ();
	sle_rsp_if rsp ();

	sorted_list_engine_unit #(.CAPACITY(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	list_cmd_t    command_backlog[$];
	list_status_t status_expected[$];

	logic signed [DATA_W-1:0] list_entries [LIST_DEPTH];
	int list_len = 0;

	int gen_len = 0;
	int queued_total = 0;
	int sent_total = 0;
	int received_total = 0;
	int fail_count = 0;
	int idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one command to the shadow list and returns the status it yields
	function automatic list_status_t apply_list_command(input list_cmd_t c);
		list_status_t s;
		int slot;
		logic signed [DATA_W-1:0] held;
		s = '0;
		s.error_code = ERR_OK;
		if (c.command == CMD_INSERT || c.command == CMD_PREPEND || c.command == CMD_APPEND) begin
			if (list_len >= LIST_DEPTH) begin
				s.error_code = ERR_FULL;
			end else begin
				slot = 0;
				if (c.command == CMD_APPEND) begin
					slot = list_len;
				end else if (c.command == CMD_INSERT) begin
					while (slot < list_len && list_entries[slot] <= c.value)
						slot++;
				end
				for (int i = list_len; i > slot; i--)
					list_entries[i] = list_entries[i-1];
				list_entries[slot] = c.value;
				list_len++;
			end
		end else if (c.command == CMD_REMOVE) begin
			if (list_len == 0)
				s.error_code = ERR_EMPTY;
			else
				list_len--;
		end else if (c.command == CMD_READ) begin
			if (list_len == 0)
				s.error_code = ERR_EMPTY;
			else if (int'(c.index) >= list_len)
				s.error_code = ERR_INDEX;
			else
				s.read_value = list_entries[c.index];
		end else if (c.command == CMD_REVERSE) begin
			for (int i = 0; i < list_len / 2; i++) begin
				held = list_entries[i];
				list_entries[i] = list_entries[list_len-1-i];
				list_entries[list_len-1-i] = held;
			end
		end
		s.is_ascending = 1'b1;
		s.is_descending = 1'b1;
		for (int i = 1; i < list_len; i++) begin
			if (list_entries[i-1] > list_entries[i])
				s.is_ascending = 1'b0;
			if (list_entries[i] > list_entries[i-1])
				s.is_descending = 1'b0;
		end
		s.entry_count = CNT_W'(list_len);
		return s;
	endfunction

	task automatic enqueue_command(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] v, input logic [IDX_W-1:0] idx);
		list_cmd_t c;
		c.command = cmd;
		c.value = v;
		c.index = idx;
		command_backlog = {command_backlog, c};
		queued_total++;
		if ((cmd == CMD_INSERT || cmd == CMD_PREPEND || cmd == CMD_APPEND) &&
				gen_len < LIST_DEPTH)
			gen_len++;
		else if (cmd == CMD_REMOVE && gen_len > 0)
			gen_len--;
	endtask

	function automatic logic signed [DATA_W-1:0] any_value();
		case ($urandom_range(0, 9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return $urandom_range(0, 1) ? '0 : '1;
			3, 4, 5: return DATA_W'(int'($urandom_range(0, 20)) - 10);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] read_index();
		if (gen_len > 0 && $urandom_range(0, 4) != 0)
			return IDX_W'($urandom_range(0, gen_len - 1));
		return IDX_W'($urandom_range(0, 63));
	endfunction

	function automatic logic [CMD_W-1:0] push_command();
		case ($urandom_range(0, 19))
			0, 1, 2: return CMD_PREPEND;
			3, 4, 5: return CMD_APPEND;
			default: return CMD_INSERT;
		endcase
	endfunction

	function automatic int send_gap_pct(input int phase);
		case (phase)
			1: return 52;
			3: return 33;
			default: return 0;
		endcase
	endfunction

	function automatic int stall_pct(input int phase);
		case (phase)
			2: return 52;
			3: return 33;
			default: return 0;
		endcase
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		list_cmd_t next_cmd;
		list_cmd_t taken;
		list_status_t predicted;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				taken.command = req.command;
				taken.value = req.value;
				taken.index = req.index;
				predicted = apply_list_command(taken);
				status_expected = {status_expected, predicted};
				sent_total++;
			end
			if (!req.valid || req.ready) begin
				if (command_backlog.size() > 0 && $urandom_range(0, 99) >=
						send_gap_pct((sent_total / ITEMS_PER_PHASE) % 4)) begin
					next_cmd = command_backlog.pop_front();
					req.valid <= 1'b1;
					req.command <= next_cmd.command;
					req.value <= next_cmd.value;
					req.index <= next_cmd.index;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		list_status_t got;
		list_status_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.read_value = rsp.read_value;
				got.entry_count = rsp.entry_count;
				got.is_ascending = rsp.is_ascending;
				got.is_descending = rsp.is_descending;
				got.error_code = rsp.error_code;
				received_total++;
				if (status_expected.size() == 0) begin
					note_failure($sformatf("unexpected status transaction %0d: rd=%0d cnt=%0d",
						received_total, got.read_value, got.entry_count));
				end else begin
					want = status_expected.pop_front();
					if (got !== want)
						note_failure($sformatf(
							{"status %0d: exp rd=%0d cnt=%0d asc=%b desc=%b err=%0d, ",
							"got rd=%0d cnt=%0d asc=%b desc=%b err=%0d"},
							received_total, want.read_value, want.entry_count, want.is_ascending,
							want.is_descending, want.error_code, got.read_value, got.entry_count,
							got.is_ascending, got.is_descending, got.error_code));
				end
			end
			rsp.ready <= $urandom_range(0, 99) >= stall_pct((received_total / ITEMS_PER_PHASE) % 4);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("sorted_list_engine_unit_test: errors");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int n;
		int base;
		int step;
		bit first_pass;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_INSERT;
		req.value = '0;
		req.index = '0;
		rsp.ready = 1'b0;

		// empty list: errors, no-op reverse, unused codes; then a short directed build, read and reverse
		enqueue_command(CMD_READ, '0, '0);
		enqueue_command(CMD_REMOVE, '1, 6'd63);
		enqueue_command(CMD_REVERSE, '0, '0);
		enqueue_command(CMD_SPARE_LO, '0, '0);
		enqueue_command(CMD_SPARE_HI, '1, '1);
		enqueue_command(CMD_INSERT, '0, '0);
		enqueue_command(CMD_REVERSE, '0, '0);
		enqueue_command(CMD_INSERT, VAL_MAX, '0);
		enqueue_command(CMD_INSERT, VAL_MIN, '0);
		enqueue_command(CMD_INSERT, '0, '0);
		enqueue_command(CMD_PREPEND, 32'sd5, '0);
		enqueue_command(CMD_APPEND, VAL_MIN, '0);
		enqueue_command(CMD_READ, '0, 6'd0);
		enqueue_command(CMD_READ, '0, 6'd5);
		enqueue_command(CMD_READ, '0, 6'd6);
		enqueue_command(CMD_READ, '0, 6'd63);
		enqueue_command(CMD_REVERSE, '0, '0);
		enqueue_command(CMD_READ, '0, 6'd1);
		enqueue_command(CMD_REMOVE, '0, 6'd42);
		enqueue_command(CMD_SPARE_HI, '0, '0);
		enqueue_command(CMD_REMOVE, '0, 6'd21);
		enqueue_command(CMD_INSERT, -32'sd1, '0);
		enqueue_command(CMD_READ, '0, 6'd2);

		first_pass = 1'b1;
		while (queued_total < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			kind = first_pass ? 0 : $urandom_range(0, 9);
			first_pass = 1'b0;
			case (kind)
				0: begin
					while (gen_len < LIST_DEPTH)
						enqueue_command(push_command(), any_value(),
							IDX_W'($urandom_range(0, 63)));
					enqueue_command(CMD_INSERT, any_value(), '0);
					enqueue_command(push_command(), any_value(), '1);
					enqueue_command(CMD_READ, '0, 6'd63);
					enqueue_command(CMD_READ, '0, 6'd0);
					enqueue_command(CMD_REVERSE, '0, '0);
					enqueue_command(CMD_READ, '0, read_index());
				end
				1, 2: begin
					while (gen_len > 0) begin
						if ($urandom_range(0, 5) == 0)
							enqueue_command(CMD_READ, any_value(), read_index());
						enqueue_command(CMD_REMOVE, any_value(), IDX_W'($urandom_range(0, 63)));
					end
					enqueue_command(CMD_REMOVE, any_value(), IDX_W'($urandom_range(0, 63)));
					enqueue_command(CMD_READ, '0, read_index());
				end
				3, 4: begin
					n = $urandom_range(2, 12);
					repeat (n)
						enqueue_command(CMD_INSERT, any_value(), IDX_W'($urandom_range(0, 63)));
					enqueue_command(CMD_READ, '0, read_index());
					enqueue_command(CMD_REVERSE, '0, '0);
					enqueue_command(CMD_READ, '0, read_index());
				end
				5: begin
					n = $urandom_range(2, 10);
					base = int'($urandom_range(0, 2000)) - 1000;
					step = $urandom_range(0, 3);
					kind = $urandom_range(0, 1);
					repeat (n) begin
						enqueue_command(kind ? CMD_PREPEND : CMD_APPEND, DATA_W'(base), '0);
						base += step;
					end
					enqueue_command(CMD_REVERSE, '0, '0);
					enqueue_command(CMD_READ, '0, read_index());
				end
				default: begin
					n = $urandom_range(3, 10);
					repeat (n)
						enqueue_command(CMD_W'($urandom_range(0, 7)), any_value(), read_index());
				end
			endcase
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (!arst_n || command_backlog.size() > 0 || req.valid || status_expected.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && status_expected.size() == 0)
			$display("sorted_list_engine_unit_test: clean");
		else
			$display("sorted_list_engine_unit_test: errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sle_pkg.sv
hw/rtl/sle_req_if.sv
hw/rtl/sle_rsp_if.sv
hw/rtl/sle_ctrl.sv
hw/rtl/sle_datapath.sv
hw/rtl/sorted_list_engine_unit.sv
tb/sv/sorted_list_engine_unit_test.sv
